>>> src/lasp_pkg.sv
// Shared types and constants for the landmark A* shortest-path block.
package lasp_pkg;

  // Input item modes
  typedef enum logic [1:0] {
    MODE_OFFSET   = 2'd0,
    MODE_EDGE     = 2'd1,
    MODE_LANDMARK = 2'd2,
    MODE_QUERY    = 2'd3
  } lasp_mode_t;

  // Configuration register indexes
  localparam logic CFG_LANDMARKS = 1'b0;
  localparam logic CFG_NODES     = 1'b1;

  // Infinite distance and expansion count ceiling
  localparam logic [31:0] INF32   = 32'hFFFF_FFFF;
  localparam logic [14:0] EXP_CAP = 15'h7FFF;

endpackage

>>> src/landmark_astar_shortest_path.sv
// Top level: graph tables, min-heap and the search sequencer.
// Load requests (modes 0-2) never raise busy; they give no result.
// A query clears the best-distance table for node_count nodes, then per pop sifts the heap
// down, scans each edge, waits for the landmark bound and sifts each push up, then finishes;
// a bad end point answers in the cycle after the request. One request at a time.
// done strobes one cycle, receiver cannot stall; rst (sync) clears control, not tables.
module landmark_astar_shortest_path #(
  parameter int MAX_NODES     = 4096,
  parameter int MAX_EDGES     = 16384,
  parameter int MAX_LANDMARKS = 8,
  parameter int HEAP_DEPTH    = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [13:0] address,
  input  logic [2:0]  landmark,
  input  logic [31:0] word,
  input  logic [23:0] weight,
  input  logic [11:0] source,
  input  logic [11:0] target,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  output logic        done,
  output logic [31:0] distance,
  output logic        reachable,
  output logic [14:0] nodes_expanded,
  output logic        heap_overflow
);
  import lasp_pkg::*;

  localparam int NW   = $clog2(MAX_NODES);
  localparam int NCW  = $clog2(MAX_NODES + 1);
  localparam int OIW  = $clog2(MAX_NODES + 1);
  localparam int OW   = $clog2(MAX_EDGES + 1);
  localparam int EW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int LIW  = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
  localparam int LW   = $clog2(MAX_LANDMARKS + 1);
  localparam int HW   = $clog2(HEAP_DEPTH);
  localparam int HSW  = $clog2(HEAP_DEPTH + 1);
  localparam int CW   = HW + 2;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_INIT, S_POP, S_POP_RD, S_SIFT_RD, S_SIFT_CMP,
    S_CHECK, S_CHECK_RD, S_OFS_RD, S_EDGE, S_EDGE_RD, S_BEST_RD,
    S_BOUND, S_PUSH_RD, S_PUSH_CMP, S_FIN, S_FIN_RD
  } state_t;

  // Heap ordering: key, then lower node id
  function automatic logic less(input logic [32:0] ak, input logic [NW-1:0] an,
                                input logic [32:0] bk, input logic [NW-1:0] bn);
    less = (ak < bk) || ((ak == bk) && (an < bn));
  endfunction

  state_t         state;
  logic [3:0]     lm_cnt;
  logic [12:0]    node_cnt;
  logic [NCW-1:0] nc;
  logic [LW-1:0]  lmn;
  logic [NW-1:0]  src, dst, clr;
  logic [HSW-1:0] hsize;
  logic [HW-1:0]  hole;
  logic [32:0]    car_key;
  logic [NW-1:0]  car_node;
  logic [31:0]    car_cost;
  logic [NW-1:0]  cur_node;
  logic [31:0]    cur_cost;
  logic [31:0]    base;
  logic [OW-1:0]  k, e_end;
  logic [NW-1:0]  t_node;
  logic [31:0]    nc2;
  logic           ovf;
  logic [14:0]    expn;

  // Memories
  logic [OW-1:0]  offs  [MAX_NODES + 1];
  logic [NW:0]    etgt  [MAX_EDGES];
  logic [23:0]    ewt   [MAX_EDGES];
  logic [31:0]    best  [MAX_NODES];
  logic [32:0]    hkey  [HEAP_DEPTH];
  logic [NW-1:0]  hnode [HEAP_DEPTH];
  logic [31:0]    hcost [HEAP_DEPTH];

  logic           accept;
  logic [31:0]    nc32, src32, dst32;
  logic           q_ok;

  logic [OIW-1:0] o_ra, o_rb;
  logic [OW-1:0]  o_da, o_db;
  logic [EW-1:0]  e_ra;
  logic [NW:0]    e_dt;
  logic [23:0]    e_dw;
  logic [NW-1:0]  b_ra, bw_addr;
  logic           bw_en;
  logic [31:0]    bw_data, b_d;
  logic [HW-1:0]  ha_ra, hb_ra, hw_idx;
  logic           hw_en;
  logic [32:0]    hw_key, ha_key, hb_key;
  logic [NW-1:0]  hw_node, ha_node, hb_node;
  logic [31:0]    hw_cost, ha_cost, hb_cost;

  logic [CW-1:0]  lidx, ridx;
  logic [HW-1:0]  parent;
  logic           sel_l, sel_r, l_in;
  logic [32:0]    min_key;
  logic [NW-1:0]  min_node;
  logic [32:0]    sum33;
  logic           b_go, b_done;
  logic [31:0]    b_bound;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Effective node count and query end point checks
  assign nc32  = (node_cnt == 13'd0) ? 32'd1 :
                 ({19'd0, node_cnt} > 32'(MAX_NODES)) ? 32'(MAX_NODES) : {19'd0, node_cnt};
  assign src32 = {20'd0, source};
  assign dst32 = {20'd0, target};
  assign q_ok  = (src32 < nc32) && (dst32 < nc32);

  // Heap child and parent positions
  assign lidx   = CW'({hole, 1'b1});
  assign ridx   = lidx + 1'b1;
  assign parent = HW'((hole - 1'b1) >> 1);

  // Pick the smallest of carried entry, left and right child
  assign l_in     = lidx < CW'(hsize);
  assign sel_l    = l_in && less(ha_key, ha_node, car_key, car_node);
  assign min_key  = sel_l ? ha_key : car_key;
  assign min_node = sel_l ? ha_node : car_node;
  assign sel_r    = (ridx < CW'(hsize)) && less(hb_key, hb_node, min_key, min_node);

  // Saturating path cost
  assign sum33 = {1'b0, base} + {9'd0, e_dw};

  // Load writes and offset/edge reads
  assign o_ra = (state == S_CHECK_RD) ? OIW'(cur_node) : OIW'(address);
  assign o_rb = OIW'(cur_node) + 1'b1;
  assign e_ra = EW'(k);

  always_ff @(posedge clk) begin
    if (accept && (mode == MODE_OFFSET) && ({18'd0, address} <= 32'(MAX_NODES))) begin
      offs[OIW'(address)] <= (word > 32'(MAX_EDGES)) ? OW'(MAX_EDGES) : OW'(word);
    end
    o_da <= offs[o_ra];
    o_db <= offs[o_rb];
  end

  always_ff @(posedge clk) begin
    if (accept && (mode == MODE_EDGE) && ({18'd0, address} < 32'(MAX_EDGES))) begin
      etgt[EW'(address)] <= {word < 32'(MAX_NODES), NW'(word)};
      ewt[EW'(address)]  <= weight;
    end
    e_dt <= etgt[e_ra];
    e_dw <= ewt[e_ra];
  end

  // Best-distance table port
  always_comb begin
    b_ra    = cur_node;
    bw_en   = 1'b0;
    bw_addr = clr;
    bw_data = INF32;
    case (state)
      S_EDGE_RD: b_ra = e_dt[NW-1:0];
      S_FIN:     b_ra = dst;
      S_CLR:     bw_en = 1'b1;
      S_INIT: begin
        bw_en   = 1'b1;
        bw_addr = src;
        bw_data = '0;
      end
      S_BEST_RD: begin
        bw_en   = (nc2 < b_d);
        bw_addr = t_node;
        bw_data = nc2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bw_en) begin
      best[bw_addr] <= bw_data;
    end
    b_d <= best[b_ra];
  end

  // Heap ports: two reads, one write
  always_comb begin
    ha_ra   = '0;
    hb_ra   = HW'(hsize - 1'b1);
    hw_en   = 1'b0;
    hw_idx  = hole;
    hw_key  = car_key;
    hw_node = car_node;
    hw_cost = car_cost;
    case (state)
      S_SIFT_RD: begin
        ha_ra = HW'(lidx);
        hb_ra = HW'(ridx);
        hw_en = !l_in;
      end
      S_SIFT_CMP: begin
        hw_en = 1'b1;
        if (sel_r) begin
          hw_key  = hb_key;
          hw_node = hb_node;
          hw_cost = hb_cost;
        end else if (sel_l) begin
          hw_key  = ha_key;
          hw_node = ha_node;
          hw_cost = ha_cost;
        end
      end
      S_INIT: begin
        hw_en   = 1'b1;
        hw_idx  = '0;
        hw_key  = '0;
        hw_node = src;
        hw_cost = '0;
      end
      S_PUSH_RD: begin
        ha_ra = parent;
        hw_en = (hole == '0);
      end
      S_PUSH_CMP: begin
        hw_en = 1'b1;
        if (less(car_key, car_node, ha_key, ha_node)) begin
          hw_key  = ha_key;
          hw_node = ha_node;
          hw_cost = ha_cost;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hw_en) begin
      hkey[hw_idx]  <= hw_key;
      hnode[hw_idx] <= hw_node;
      hcost[hw_idx] <= hw_cost;
    end
    ha_key  <= hkey[ha_ra];
    ha_node <= hnode[ha_ra];
    ha_cost <= hcost[ha_ra];
    hb_key  <= hkey[hb_ra];
    hb_node <= hnode[hb_ra];
    hb_cost <= hcost[hb_ra];
  end

  // Landmark bound unit
  assign b_go = (state == S_BEST_RD) && (nc2 < b_d);

  lasp_bound #(
    .MAX_NODES     (MAX_NODES),
    .MAX_LANDMARKS (MAX_LANDMARKS)
  ) u_bound (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && (mode == MODE_LANDMARK) &&
              ({29'd0, landmark} < 32'(MAX_LANDMARKS)) &&
              ({18'd0, address} < 32'(MAX_NODES))),
    .wr_lm   (LIW'(landmark)),
    .wr_node (NW'(address)),
    .wr_data (word),
    .go      (b_go),
    .node    (t_node),
    .goal    (dst),
    .count   (lmn),
    .done    (b_done),
    .bound   (b_bound)
  );

  // Search sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      lm_cnt   <= '0;
      node_cnt <= 13'd1;
      hsize    <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_LANDMARKS) begin
          lm_cnt <= cfg_data[3:0];
        end else begin
          node_cnt <= cfg_data;
        end
      end
      case (state)
        S_IDLE: begin
          if (accept && (mode == MODE_QUERY)) begin
            if (q_ok) begin
              nc    <= NCW'(nc32);
              lmn   <= ({28'd0, lm_cnt} > 32'(MAX_LANDMARKS)) ? LW'(MAX_LANDMARKS)
                                                               : LW'(lm_cnt);
              src   <= NW'(source);
              dst   <= NW'(target);
              clr   <= '0;
              expn  <= '0;
              ovf   <= 1'b0;
              hsize <= '0;
              state <= S_CLR;
            end else begin
              distance       <= INF32;
              reachable      <= 1'b0;
              nodes_expanded <= '0;
              heap_overflow  <= 1'b0;
              done           <= 1'b1;
            end
          end
        end
        S_CLR: begin
          clr <= clr + 1'b1;
          if (NCW'(clr) == nc - 1'b1) begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          hsize <= HSW'(1);
          state <= S_POP;
        end
        S_POP: begin
          if (hsize == '0) begin
            state <= S_FIN;
          end else begin
            hsize <= hsize - 1'b1;
            state <= S_POP_RD;
          end
        end
        S_POP_RD: begin
          cur_node <= ha_node;
          cur_cost <= ha_cost;
          car_key  <= hb_key;
          car_node <= hb_node;
          car_cost <= hb_cost;
          hole     <= '0;
          state    <= (hsize == '0) ? S_CHECK : S_SIFT_RD;
        end
        S_SIFT_RD: begin
          state <= l_in ? S_SIFT_CMP : S_CHECK;
        end
        S_SIFT_CMP: begin
          if (sel_r) begin
            hole  <= HW'(ridx);
            state <= S_SIFT_RD;
          end else if (sel_l) begin
            hole  <= HW'(lidx);
            state <= S_SIFT_RD;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= (cur_node == dst) ? S_FIN : S_CHECK_RD;
        end
        S_CHECK_RD: begin
          if (cur_cost > b_d) begin
            state <= S_POP;
          end else begin
            if (expn != EXP_CAP) begin
              expn <= expn + 1'b1;
            end
            base  <= b_d;
            state <= S_OFS_RD;
          end
        end
        S_OFS_RD: begin
          k     <= o_da;
          e_end <= o_db;
          state <= S_EDGE;
        end
        S_EDGE: begin
          state <= (k < e_end) ? S_EDGE_RD : S_POP;
        end
        S_EDGE_RD: begin
          if (!e_dt[NW] || (NCW'(e_dt[NW-1:0]) >= nc)) begin
            k     <= k + 1'b1;
            state <= S_EDGE;
          end else begin
            t_node <= e_dt[NW-1:0];
            nc2    <= sum33[32] ? INF32 : sum33[31:0];
            state  <= S_BEST_RD;
          end
        end
        S_BEST_RD: begin
          if (nc2 < b_d) begin
            state <= S_BOUND;
          end else begin
            k     <= k + 1'b1;
            state <= S_EDGE;
          end
        end
        S_BOUND: begin
          if (b_done) begin
            car_key  <= {1'b0, nc2} + {1'b0, b_bound};
            car_node <= t_node;
            car_cost <= nc2;
            if (hsize >= HSW'(HEAP_DEPTH)) begin
              ovf   <= 1'b1;
              k     <= k + 1'b1;
              state <= S_EDGE;
            end else begin
              hole  <= HW'(hsize);
              hsize <= hsize + 1'b1;
              state <= S_PUSH_RD;
            end
          end
        end
        S_PUSH_RD: begin
          if (hole == '0) begin
            k     <= k + 1'b1;
            state <= S_EDGE;
          end else begin
            state <= S_PUSH_CMP;
          end
        end
        S_PUSH_CMP: begin
          if (less(car_key, car_node, ha_key, ha_node)) begin
            hole  <= parent;
            state <= S_PUSH_RD;
          end else begin
            k     <= k + 1'b1;
            state <= S_EDGE;
          end
        end
        S_FIN: begin
          hsize <= '0;
          state <= S_FIN_RD;
        end
        S_FIN_RD: begin
          distance       <= b_d;
          reachable      <= (b_d != INF32);
          nodes_expanded <= expn;
          heap_overflow  <= ovf;
          done           <= 1'b1;
          state          <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A result is shown only once the block has gone idle
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  // Reachable flag agrees with the distance
  assert property (@(posedge clk) disable iff (rst) done |-> (reachable == (distance != INF32)))
    else $error("reachable flag disagrees with distance");
  // Every finished query delivers a result
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("query ended without a result");
  // Heap never grows past its depth
  assert property (@(posedge clk) disable iff (rst) hsize <= HSW'(HEAP_DEPTH))
    else $error("heap size out of range");
`endif

endmodule

>>> src/lasp_bound.sv
// Landmark lower-bound unit: holds the landmark distance table, one landmark per cycle.
module lasp_bound #(
  parameter int MAX_NODES     = 4096,
  parameter int MAX_LANDMARKS = 8,
  parameter int NW  = $clog2(MAX_NODES),
  parameter int LIW = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1,
  parameter int LW  = $clog2(MAX_LANDMARKS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [LIW-1:0] wr_lm,
  input  logic [NW-1:0] wr_node,
  input  logic [31:0]   wr_data,
  input  logic          go,
  input  logic [NW-1:0] node,
  input  logic [NW-1:0] goal,
  input  logic [LW-1:0] count,
  output logic          done,
  output logic [31:0]   bound
);
  import lasp_pkg::*;

  localparam int DEPTH = MAX_LANDMARKS * MAX_NODES;
  localparam int LAW   = $clog2(DEPTH);

  logic [31:0]   lmd [DEPTH];
  logic [31:0]   da, db;
  logic          run, pend;
  logic [LW-1:0] idx;
  logic [LAW-1:0] base_addr, ra, rb, wa;
  logic [31:0]   diff;
  logic          take;

  // Table addresses: landmark-major rows
  assign base_addr = LAW'(idx) * LAW'(MAX_NODES);
  assign ra = base_addr + LAW'(node);
  assign rb = base_addr + LAW'(goal);
  assign wa = LAW'(wr_lm) * LAW'(MAX_NODES) + LAW'(wr_node);

  // Table write and registered dual read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      lmd[wa] <= wr_data;
    end
    da <= lmd[ra];
    db <= lmd[rb];
  end

  // Candidate bound from the landmark whose data just returned
  assign diff = da - db;
  assign take = pend && (da != INF32) && (db != INF32) && (da > db) && (diff > bound);

  // Sequencer over landmarks
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      pend <= 1'b0;
      idx  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run   <= 1'b1;
        pend  <= 1'b0;
        idx   <= '0;
        bound <= '0;
      end else if (run) begin
        if (take) begin
          bound <= diff;
        end
        if (idx < count) begin
          pend <= 1'b1;
          idx  <= idx + 1'b1;
        end else begin
          pend <= 1'b0;
          if (!pend) begin
            run  <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

endmodule
